/* sv/ssgr_pkg.sv */
// ----------------------------------------------------------------------------
// ssgr_pkg
// types, codes and constants shared by the step generator modules
// ----------------------------------------------------------------------------
package ssgr_pkg;

	// full-scale speed and phase accumulator modulus
	localparam int SPEED_FULL = 127;

	// default depth of the command queue between front and back
	localparam int QUEUE_DEPTH_DEF = 4;

	// request codes on the input channel
	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_MOVE  = 2'd1;
	localparam logic [1:0] REQ_SPEED = 2'd2;

	// classified command codes carried through the queue
	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_MOVE  = 2'd1;
	localparam logic [1:0] CMD_SPEED = 2'd2;
	localparam logic [1:0] CMD_NOP   = 2'd3;

	// step pulse codes
	localparam logic [1:0] PULSE_NONE = 2'd0;
	localparam logic [1:0] PULSE_FWD  = 2'd1;
	localparam logic [1:0] PULSE_REV  = 2'd2;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_STEP    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_EVERY   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STEPS_PER_REV = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INVERT_DIR    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_CONN    = 3'd4;

	typedef struct packed {
		logic [1:0]         req_type;
		logic signed [15:0] move_steps;
		logic signed [7:0]  speed_request;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         step_pulse;
		logic signed [7:0]  motor_speed;
		logic [15:0]        position;
		logic               move_done;
		logic signed [15:0] steps_left;
	} out_item_t;

	// command after classification, speed already saturated
	typedef struct packed {
		logic [1:0]         kind;
		logic signed [15:0] move_steps;
		logic signed [7:0]  speed;
	} cmd_t;

	typedef struct packed {
		logic [6:0]  accel_step;
		logic [15:0] accel_every;
		logic [15:0] steps_per_rev;
		logic        invert_direction;
		logic        motor_connected;
	} cfg_t;

	typedef struct packed {
		logic        start;
		logic [15:0] dividend;
		logic [15:0] divisor;
	} mod_req_t;

	typedef struct packed {
		logic done;
		logic is_zero;
	} mod_rsp_t;

endpackage

/* sv/ssgr_front.sv */
// ----------------------------------------------------------------------------
// ssgr_front
// accepts input transactions, classifies them and pushes commands to the queue
// ----------------------------------------------------------------------------
module ssgr_front (
	input  logic             in_valid,
	output logic             in_stall,
	input  ssgr_pkg::in_item_t in_data,
	input  logic             q_full,
	output logic             q_push,
	output ssgr_pkg::cmd_t   q_cmd
);
	import ssgr_pkg::*;

	localparam logic signed [7:0] SPD_MAX = 8'(SPEED_FULL);

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		q_cmd.move_steps = in_data.move_steps;
		// saturate the requested speed to full scale
		if (in_data.speed_request > SPD_MAX) begin
			q_cmd.speed = SPD_MAX;
		end else if (in_data.speed_request < -SPD_MAX) begin
			q_cmd.speed = -SPD_MAX;
		end else begin
			q_cmd.speed = in_data.speed_request;
		end
		case (in_data.req_type)
			REQ_TICK: begin
				q_cmd.kind = CMD_TICK;
			end
			REQ_MOVE: begin
				// a zero-length move changes nothing
				q_cmd.kind = (in_data.move_steps == 16'sd0) ? CMD_NOP : CMD_MOVE;
			end
			REQ_SPEED: begin
				q_cmd.kind = CMD_SPEED;
			end
			default: begin
				q_cmd.kind = CMD_NOP;
			end
		endcase
	end

endmodule

/* sv/ssgr_fifo.sv */
// ----------------------------------------------------------------------------
// ssgr_fifo
// short command queue between front and back
// ----------------------------------------------------------------------------
module ssgr_fifo #(
	parameter int DEPTH = ssgr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ssgr_pkg::cmd_t push_cmd,
	input  logic           pop,
	output ssgr_pkg::cmd_t head_cmd,
	output logic           full,
	output logic           empty
);
	import ssgr_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	cmd_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_FULL);
	assign empty    = (count_q == '0);
	assign head_cmd = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* sv/ssgr_mod.sv */
// ----------------------------------------------------------------------------
// ssgr_mod
// bit-serial remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
module ssgr_mod (
	input  logic               clk,
	input  logic               arst_n,
	input  ssgr_pkg::mod_req_t req,
	output ssgr_pkg::mod_rsp_t rsp
);
	import ssgr_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [3:0]  cnt_q;
	logic [15:0] num_q;
	logic [15:0] div_q;
	logic [15:0] rem_q;
	logic [16:0] trial;

	assign trial = {rem_q, num_q[15]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			// one-cycle pulse after the last dividend bit
			done_q <= busy_q && !req.start && (cnt_q == 4'hf);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 4'hf) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.dividend;
			div_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[14:0], 1'b0};
			if (trial >= {1'b0, div_q}) begin
				rem_q <= 16'(trial - {1'b0, div_q});
			end else begin
				rem_q <= trial[15:0];
			end
		end
	end

	assign rsp.done    = done_q;
	assign rsp.is_zero = (rem_q == '0);

endmodule

/* sv/ssgr_back.sv */
// ----------------------------------------------------------------------------
// ssgr_back
// executes queued commands: ramp, phase accumulation, stepping, result register
// ----------------------------------------------------------------------------
module ssgr_back (
	input  logic                clk,
	input  logic                arst_n,
	input  ssgr_pkg::cfg_t      cfg,
	input  logic                q_empty,
	input  ssgr_pkg::cmd_t      q_head,
	output logic                q_pop,
	output ssgr_pkg::mod_req_t  mod_req,
	input  ssgr_pkg::mod_rsp_t  mod_rsp,
	output logic                out_valid,
	input  logic                out_stall,
	output ssgr_pkg::out_item_t out_data
);
	import ssgr_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MOD   = 3'd1;
	localparam logic [2:0] ST_GOAL  = 3'd2;
	localparam logic [2:0] ST_RAMP  = 3'd3;
	localparam logic [2:0] ST_STEP  = 3'd4;
	localparam logic [2:0] ST_APPLY = 3'd5;

	localparam logic signed [8:0]  FULL9  = 9'(SPEED_FULL);
	localparam logic signed [9:0]  FULL10 = 10'(SPEED_FULL);
	localparam logic signed [23:0] FULL24 = 24'(SPEED_FULL);
	localparam logic signed [7:0]  FULL8  = 8'(SPEED_FULL);

	logic [2:0]         state_q;
	cmd_t               cmd_q;
	logic signed [7:0]  speed_q;
	logic [6:0]         phase_q;
	logic [15:0]        pos_q;
	logic signed [15:0] rem_q;
	logic               cont_q;
	logic [15:0]        tick_q;
	logic signed [7:0]  target_q;
	logic signed [7:0]  goal_q;
	logic               out_valid_q;
	out_item_t          out_q;

	logic               ramp_en;
	logic               out_free;
	logic               finish;
	logic signed [23:0] prod;
	logic signed [7:0]  goal;
	logic signed [8:0]  dgap;
	logic signed [8:0]  amax9;
	logic signed [8:0]  diff;
	logic signed [9:0]  sum10;
	logic signed [7:0]  ramped;
	logic signed [8:0]  ph9;
	logic [15:0]        pos_up;
	logic [15:0]        pos_base;

	logic signed [7:0]  n_speed;
	logic [6:0]         n_phase;
	logic [15:0]        n_pos;
	logic signed [15:0] n_rem;
	logic               n_cont;
	logic signed [7:0]  n_target;
	logic [1:0]         n_pulse;
	logic               n_done;

	assign ramp_en  = (cfg.accel_every != '0) && (cfg.accel_step != '0);
	assign out_free = !out_valid_q || !out_stall;
	assign finish   = ((state_q == ST_STEP) || (state_q == ST_APPLY)) && out_free;
	assign q_pop    = (state_q == ST_IDLE) && !q_empty;

	assign mod_req.start    = q_pop && (q_head.kind == CMD_TICK) && ramp_en;
	assign mod_req.dividend = tick_q;
	assign mod_req.divisor  = cfg.accel_every;

	// ramp goal, the target speed in continuous mode or a braking profile in move mode
	assign prod = $signed({{8{rem_q[15]}}, rem_q}) * $signed({17'd0, cfg.accel_step});

	always_comb begin
		if (cont_q) begin
			goal = target_q;
		end else if ((rem_q > 16'sd0) && !speed_q[7]) begin
			goal = (prod > FULL24) ? FULL8 : prod[7:0];
		end else if ((rem_q < 16'sd0) && (speed_q[7] || (speed_q == 8'sd0))) begin
			goal = (prod < -FULL24) ? -FULL8 : prod[7:0];
		end else begin
			goal = 8'sd0;
		end
	end

	// step toward the goal by at most accel_step
	assign amax9 = $signed({2'b00, cfg.accel_step});
	assign dgap  = $signed({goal_q[7], goal_q}) - $signed({speed_q[7], speed_q});

	always_comb begin
		if (dgap > amax9) begin
			diff = amax9;
		end else if (dgap < -amax9) begin
			diff = -amax9;
		end else begin
			diff = dgap;
		end
		sum10 = $signed({{2{speed_q[7]}}, speed_q}) + $signed({diff[8], diff});
		if (sum10 > FULL10) begin
			ramped = FULL8;
		end else if (sum10 < -FULL10) begin
			ramped = -FULL8;
		end else begin
			ramped = sum10[7:0];
		end
	end

	// phase accumulation and position update
	assign ph9      = $signed({2'b00, phase_q}) + $signed({speed_q[7], speed_q});
	assign pos_up   = pos_q + 16'd1;
	assign pos_base = (pos_q == '0) ? cfg.steps_per_rev : pos_q;

	always_comb begin
		n_speed  = speed_q;
		n_phase  = phase_q;
		n_pos    = pos_q;
		n_rem    = rem_q;
		n_cont   = cont_q;
		n_target = target_q;
		n_pulse  = PULSE_NONE;
		n_done   = 1'b0;
		if (state_q == ST_APPLY) begin
			case (cmd_q.kind)
				CMD_MOVE: begin
					n_cont = 1'b0;
					n_rem  = cmd_q.move_steps;
				end
				CMD_SPEED: begin
					n_target = cmd_q.speed;
					n_cont   = 1'b1;
					n_rem    = 16'sd0;
				end
				default: begin
				end
			endcase
		end else if ((speed_q != 8'sd0) && cfg.motor_connected) begin
			if (ph9 < 9'sd0) begin
				n_phase = 7'(ph9 + FULL9);
				n_pulse = PULSE_REV;
				n_pos   = pos_base - 16'd1;
			end else if (ph9 >= FULL9) begin
				n_phase = 7'(ph9 - FULL9);
				n_pulse = PULSE_FWD;
				n_pos   = (pos_up >= cfg.steps_per_rev) ? pos_up - cfg.steps_per_rev : pos_up;
			end else begin
				n_phase = ph9[6:0];
			end
			if ((n_pulse != PULSE_NONE) && !cont_q) begin
				n_rem = (n_pulse == PULSE_FWD) ? rem_q - 16'sd1 : rem_q + 16'sd1;
				// move target reached: brake and return to continuous mode
				if (n_rem == 16'sd0) begin
					n_target = 8'sd0;
					n_speed  = 8'sd0;
					n_phase  = '0;
					n_cont   = 1'b1;
					n_done   = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			speed_q     <= '0;
			phase_q     <= '0;
			pos_q       <= '0;
			rem_q       <= '0;
			cont_q      <= 1'b1;
			tick_q      <= '0;
			target_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a new result loads, or a stalled one is held
			out_valid_q <= finish || (out_valid_q && out_stall);
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						if (q_head.kind == CMD_TICK) begin
							tick_q  <= tick_q + 16'd1;
							state_q <= ramp_en ? ST_MOD : ST_STEP;
						end else begin
							state_q <= ST_APPLY;
						end
					end
				end
				ST_MOD: begin
					if (mod_rsp.done) begin
						state_q <= mod_rsp.is_zero ? ST_GOAL : ST_STEP;
					end
				end
				ST_GOAL: begin
					state_q <= ST_RAMP;
				end
				ST_RAMP: begin
					if (diff != 9'sd0) begin
						speed_q <= ramped;
						if (ramped == 8'sd0) begin
							phase_q <= '0;
						end
					end
					state_q <= ST_STEP;
				end
				ST_STEP, ST_APPLY: begin
					if (out_free) begin
						speed_q     <= n_speed;
						phase_q     <= n_phase;
						pos_q       <= n_pos;
						rem_q       <= n_rem;
						cont_q      <= n_cont;
						target_q    <= n_target;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_head;
		end
		if (state_q == ST_GOAL) begin
			goal_q <= goal;
		end
		if (finish) begin
			out_q.step_pulse  <= n_pulse;
			out_q.motor_speed <= cfg.invert_direction ? -n_speed : n_speed;
			out_q.position    <= n_pos;
			out_q.move_done   <= n_done;
			out_q.steps_left  <= n_rem;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

/* sv/stepper_step_generator_with_ramp_core.sv */
// ----------------------------------------------------------------------------
// stepper_step_generator_with_ramp_core
// single-motor step pulse generator with acceleration ramp and move braking
// ----------------------------------------------------------------------------
// usage
//   in channel (in_valid/in_stall/in_data): timer ticks, relative moves and
//   continuous speed requests; a transaction is taken when in_valid is high
//   and in_stall is low. in_stall rises only while the command queue is full
//   out channel (out_valid/out_stall/out_data): exactly one result per input
//   transaction, in order, held in an output register while out_stall is high
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): register writes,
//   always ready, to be used only while the block is idle
// command flow
//   moves, speed requests, ignored codes and ticks with ramping off pass
//   through the queue, the apply or step state and the output register;
//   the back part takes a new command only once its last result is loaded
//   ticks with ramping on always wait for the bit-serial tick_counter modulo
//   accel_every unit, and a tick that lands on a ramp update then passes
//   through the goal and ramp states before the step state
// reset
//   arst_n clears queue, motor state and registers to their defaults; a
//   stalled receiver fills the output register, then the queue, then in_stall
// ----------------------------------------------------------------------------
module stepper_step_generator_with_ramp_core #(
	parameter int QUEUE_DEPTH = ssgr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  ssgr_pkg::in_item_t                 in_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output ssgr_pkg::out_item_t                out_data,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ssgr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [15:0]                        cfg_data
);
	import ssgr_pkg::*;

	// configuration registers
	cfg_t     cfg_q;

	// front to queue
	logic     q_push;
	cmd_t     q_push_cmd;
	logic     q_full;

	// queue to back
	logic     q_pop;
	logic     q_empty;
	cmd_t     q_head;

	// back to remainder unit
	mod_req_t mod_req;
	mod_rsp_t mod_rsp;

	// writes are taken at any time
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.accel_step       <= 7'd1;
			cfg_q.accel_every      <= 16'd1;
			cfg_q.steps_per_rev    <= 16'd200;
			cfg_q.invert_direction <= 1'b0;
			cfg_q.motor_connected  <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ACCEL_STEP:    cfg_q.accel_step       <= cfg_data[6:0];
				CFG_ACCEL_EVERY:   cfg_q.accel_every      <= cfg_data;
				CFG_STEPS_PER_REV: cfg_q.steps_per_rev    <= cfg_data;
				CFG_INVERT_DIR:    cfg_q.invert_direction <= cfg_data[0];
				CFG_MOTOR_CONN:    cfg_q.motor_connected  <= cfg_data[0];
				default: begin
					// writes beyond the register list are dropped
				end
			endcase
		end
	end

	// classify incoming transactions
	ssgr_front u_front (
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (q_push_cmd)
	);

	// decoupling queue so the input side keeps flowing during long ticks
	ssgr_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_push_cmd),
		.pop      (q_pop),
		.head_cmd (q_head),
		.full     (q_full),
		.empty    (q_empty)
	);

	// tick_counter modulo accel_every for the ramp interval
	ssgr_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mod_req),
		.rsp    (mod_rsp)
	);

	// motor state, ramp and stepping, output register
	ssgr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.mod_req   (mod_req),
		.mod_rsp   (mod_rsp),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
